FILE: rtl/core/pcrf_pkg.sv
// Shared constants, command and status types for the parent chain root finder.
`default_nettype none

package pcrf_pkg;

  // Sizing of the node tables.
  localparam int MAX_NODES    = 1024;
  localparam int NUM_FILES    = 4;
  localparam int CHAIN_PASSES = 4;

  // Derived widths.
  localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int FILE_W = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int NF_W   = $clog2(NUM_FILES + 1);
  localparam int LVL_W  = (CHAIN_PASSES > 1) ? $clog2(CHAIN_PASSES) : 1;
  localparam int ADDR_W = $clog2(NUM_FILES * MAX_NODES);

  // Fixed field widths of the transactions.
  localparam int REQ_W       = 2;
  localparam int EFILE_W     = 2;
  localparam int ID_W        = 32;
  localparam int NIDX_W      = 10;
  localparam int CFG_NF_W    = 3;
  localparam int ENTRY_W     = 2 * ID_W;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 16;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_NUM_FILES = '0;
  localparam logic [CFG_NF_W-1:0] NUM_FILES_RST = CFG_NF_W'(4);

  // Parent id that marks a root.
  localparam logic [ID_W-1:0] NO_PARENT = '1;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              clear;
    logic              load;
    logic              query_cap;
    logic              rd_en;
    logic              scan;
    logic [FILE_W-1:0] rd_file;
    logic [IDX_W-1:0]  rd_index;
    logic              cmp_en;
    logic              root_load;
    logic              res_self;
    logic              res_miss;
    logic              out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              q_valid;
    logic [FILE_W-1:0] q_file;
    logic [IDX_W-1:0]  q_index;
    logic [CNT_W-1:0]  cur_cnt;
    logic [NF_W-1:0]   nf;
    logic              root_top;
    logic              hit;
    logic              out_free;
  } sts_t;

  // Flat table address of entry k of file f.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [FILE_W-1:0] f,
                                                  input logic [IDX_W-1:0] k);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(f) * ADDR_W'(MAX_NODES);
    return base + ADDR_W'(k);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pcrf_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module pcrf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: write or registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pcrf_dp.sv
// Datapath: node tables, entry counts, chain compare, result and config registers.
`default_nettype none

module pcrf_dp
  import pcrf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cmd_t                   cmd,
  output sts_t                        sts,
  input  wire logic [EFILE_W-1:0]     in_entry_file,
  input  wire logic [ID_W-1:0]        in_node_id,
  input  wire logic [ID_W-1:0]        in_parent_id,
  input  wire logic [NIDX_W-1:0]      in_node_index,
  input  wire logic                   out_tready,
  output logic                        out_tvalid,
  output logic      [NIDX_W-1:0]      out_up_index,
  output logic      [EFILE_W-1:0]     out_up_file,
  output logic                        out_found,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [PDATA_W-1:0]     pwdata,
  output logic      [PDATA_W-1:0]     prdata
);

  logic [CNT_W-1:0]    cnt_r [NUM_FILES];
  logic [EFILE_W-1:0]  q_file_r;
  logic [NIDX_W-1:0]   q_idx_r;
  logic [ID_W-1:0]     sought_r;
  logic                scan_v_r;
  logic [FILE_W-1:0]   tag_file_r;
  logic [IDX_W-1:0]    tag_k_r;
  logic [NIDX_W-1:0]   res_index_r;
  logic [EFILE_W-1:0]  res_file_r;
  logic                res_found_r;
  logic                out_tvalid_r;
  logic [NIDX_W-1:0]   out_index_r;
  logic [EFILE_W-1:0]  out_file_r;
  logic                out_found_r;
  logic [CFG_NF_W-1:0] num_files_r;

  logic [FILE_W-1:0]   ld_sel;
  logic                ld_ok;
  logic [FILE_W-1:0]   q_sel;
  logic [ADDR_W-1:0]   ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [ID_W-1:0]     rd_id;
  logic [ID_W-1:0]     rd_par;
  logic                match;
  logic                hit;
  logic                cfg_wr;
  logic                cfg_hit;

  // Load decode: the entry is dropped for a file out of range or a full table.
  assign ld_sel = FILE_W'(in_entry_file);
  assign ld_ok  = cmd.load && (int'(in_entry_file) < NUM_FILES) &&
                  (cnt_r[ld_sel] < CNT_W'(MAX_NODES));

  // Table memory, one entry holds {parent id, node id}.
  assign ram_wdata = {in_parent_id, in_node_id};
  assign ram_addr  = ld_ok ? slot_addr(ld_sel, cnt_r[ld_sel][IDX_W-1:0])
                           : slot_addr(cmd.rd_file, cmd.rd_index);

  pcrf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_FILES * MAX_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ld_ok),
    .re    (cmd.rd_en),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_id  = ram_rdata[ID_W-1:0];
  assign rd_par = ram_rdata[ENTRY_W-1:ID_W];

  // Entry counts per file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FILES; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cmd.clear) begin
      for (int i = 0; i < NUM_FILES; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (ld_ok) begin
      cnt_r[ld_sel] <= cnt_r[ld_sel] + CNT_W'(1);
    end
  end

  // Query fields held for the whole search.
  always_ff @(posedge clk) begin
    if (cmd.query_cap) begin
      q_file_r <= in_entry_file;
      q_idx_r  <= in_node_index;
    end
  end

  assign q_sel = FILE_W'(q_file_r);

  // Tag of the scan read in flight, compared in the cycle after issue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_v_r <= 1'b0;
    end else begin
      scan_v_r <= cmd.rd_en && cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    tag_file_r <= cmd.rd_file;
    tag_k_r    <= cmd.rd_index;
  end

  // Chain step: a matching entry moves the sought id to its parent.
  assign match = cmd.cmp_en && scan_v_r && (rd_id == sought_r);
  assign hit   = match && (rd_par == NO_PARENT);

  always_ff @(posedge clk) begin
    if (cmd.root_load || match) begin
      sought_r <= rd_par;
    end
  end

  // Pending result of the current query.
  always_ff @(posedge clk) begin
    if (hit) begin
      res_index_r <= NIDX_W'(tag_k_r);
      res_file_r  <= EFILE_W'(tag_file_r);
      res_found_r <= 1'b1;
    end else if (cmd.res_self || cmd.res_miss) begin
      res_index_r <= q_idx_r;
      res_file_r  <= q_file_r;
      res_found_r <= cmd.res_self;
    end
  end

  // Output register, free again once its transaction is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index_r <= res_index_r;
      out_file_r  <= res_file_r;
      out_found_r <= res_found_r;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_up_index = out_index_r;
  assign out_up_file  = out_file_r;
  assign out_found    = out_found_r;

  // Configuration register.
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_NUM_FILES);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_files_r <= NUM_FILES_RST;
    end else if (cfg_wr) begin
      num_files_r <= pwdata[CFG_NF_W-1:0];
    end
  end

  assign prdata = cfg_hit ? PDATA_W'(num_files_r) : '0;

  // Status toward the controller.
  always_comb begin
    sts          = '0;
    sts.q_valid  = (int'(q_file_r) < NUM_FILES) && (CNT_W'(q_idx_r) < cnt_r[q_sel]);
    sts.q_file   = q_sel;
    sts.q_index  = IDX_W'(q_idx_r);
    sts.cur_cnt  = cnt_r[cmd.rd_file];
    sts.nf       = (int'(num_files_r) > NUM_FILES) ? NF_W'(NUM_FILES) : NF_W'(num_files_r);
    sts.root_top = (rd_par == NO_PARENT);
    sts.hit      = hit;
    sts.out_free = !out_tvalid_r || out_tready;
  end

`ifndef SYNTHESIS
  a_hit_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
    hit |=> res_found_r)
    else $error("root hit did not mark the pending result as found");

  a_out_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid_r)
    else $error("result load did not raise out_tvalid");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/pcrf_ctrl.sv
// Controller: request decode and sequencing of the chain-following scans.
`default_nettype none

module pcrf_ctrl
  import pcrf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [REQ_W-1:0] in_req_type,
  input  wire sts_t             sts,
  output cmd_t                  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_ROOT  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_RESP  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [FILE_W-1:0] file_r, file_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic              own_r, own_nxt;
  logic              accept;
  logic              lvl_last;
  logic              k_last;
  logic              file_last;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign lvl_last  = (lvl_r == LVL_W'(CHAIN_PASSES - 1));
  assign k_last    = !((CNT_W'(k_r) + CNT_W'(1)) < sts.cur_cnt);
  assign file_last = !((NF_W'(file_r) + NF_W'(1)) < sts.nf);

  // Next state, scan position and datapath commands.
  always_comb begin
    state_nxt = state_r;
    file_nxt  = file_r;
    k_nxt     = k_r;
    lvl_nxt   = lvl_r;
    own_nxt   = own_r;
    cmd       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_CLEAR: cmd.clear = 1'b1;
            REQ_LOAD:  cmd.load = 1'b1;
            REQ_QUERY: begin
              cmd.query_cap = 1'b1;
              state_nxt     = ST_CHECK;
            end
            default: ;
          endcase
        end
      end

      // Range check, then read the queried entry.
      ST_CHECK: begin
        cmd.rd_file  = sts.q_file;
        cmd.rd_index = sts.q_index;
        if (sts.q_valid) begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_ROOT;
        end else begin
          cmd.res_miss = 1'b1;
          state_nxt    = ST_RESP;
        end
      end

      // The queried entry's parent becomes the first sought id; an entry with no parent is its own root.
      ST_ROOT: begin
        cmd.root_load = 1'b1;
        if (sts.root_top) begin
          cmd.res_self = 1'b1;
          state_nxt    = ST_RESP;
        end else begin
          file_nxt  = sts.q_file;
          k_nxt     = '0;
          lvl_nxt   = '0;
          own_nxt   = 1'b1;
          state_nxt = ST_SCAN;
        end
      end

      // One entry read per cycle while the file has entries; the compare comes in the cycle after the read.
      ST_SCAN: begin
        cmd.cmp_en   = 1'b1;
        cmd.rd_file  = file_r;
        cmd.rd_index = k_r;
        if (sts.hit) begin
          state_nxt = ST_RESP;
        end else begin
          cmd.scan  = 1'b1;
          cmd.rd_en = CNT_W'(k_r) < sts.cur_cnt;
          if (!k_last) begin
            k_nxt = k_r + IDX_W'(1);
          end else begin
            k_nxt = '0;
            if (own_r) begin
              if (lvl_last) begin
                own_nxt  = 1'b0;
                lvl_nxt  = '0;
                file_nxt = '0;
                if (sts.nf == '0) begin
                  state_nxt = ST_DRAIN;
                end
              end else begin
                lvl_nxt = lvl_r + LVL_W'(1);
              end
            end else if (file_last) begin
              file_nxt = '0;
              if (lvl_last) begin
                state_nxt = ST_DRAIN;
              end else begin
                lvl_nxt = lvl_r + LVL_W'(1);
              end
            end else begin
              file_nxt = file_r + FILE_W'(1);
            end
          end
        end
      end

      // Compare of the last read, then give up if no root was hit.
      ST_DRAIN: begin
        cmd.cmp_en = 1'b1;
        if (!sts.hit) begin
          cmd.res_miss = 1'b1;
        end
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      own_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      own_r   <= own_nxt;
    end
  end

  always_ff @(posedge clk) begin
    file_r <= file_nxt;
    k_r    <= k_nxt;
    lvl_r  <= lvl_nxt;
  end

`ifndef SYNTHESIS
  a_hit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    sts.hit |-> (state_r == ST_SCAN || state_r == ST_DRAIN))
    else $error("root hit reported outside of a scan");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded while the output register is still full");

  a_no_rd_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.rd_en)
    else $error("table read issued in the same cycle as a load");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/parent_chain_root_finder_core.sv
// Top level of the parent chain root finder: stream ports, config port, controller, datapath.
//
//  Channel   Direction  Handshake                    Contents
//  in_       slave      in_tvalid / in_tready        clear, load or query transaction
//  out_      master     out_tvalid / out_tready      root index, file and found flag
//  cfg (APB) slave      psel, penable, pready = 1    num_files register at byte 0
//
// A query past the file's count misses after the range check, and a node with no parent is
// its own root; otherwise the chain is followed through CHAIN_PASSES passes over its own file,
// then CHAIN_PASSES passes over the first num_files files, one table read per cycle on a
// single RAM port, ending early when a root is hit.
// Reset is synchronous, active low; it empties all tables and sets num_files to 4.
// The result waits in an output register; the next item is taken meanwhile, and a new
// result holds back the controller only while that register is still full.
`default_nettype none

module parent_chain_root_finder_core
  import pcrf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // tuser: req_type[1:0]
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // tdata: entry_file[1:0], node_id[33:2], parent_id[65:34], node_index[75:66]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [REQ_W-1:0]       in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // tdata: up_index[9:0], up_file[11:10]
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  // tuser: found[0]
  output logic                        out_tuser,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [PDATA_W-1:0]     pwdata,
  output logic      [PDATA_W-1:0]     prdata,
  output logic                        pready
);

  cmd_t                cmd;
  sts_t                sts;
  logic [NIDX_W-1:0]   up_index;
  logic [EFILE_W-1:0]  up_file;

  assign pready = 1'b1;

  pcrf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_req_type (in_tuser),
    .sts         (sts),
    .cmd         (cmd)
  );

  pcrf_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_entry_file (in_tdata[1:0]),
    .in_node_id    (in_tdata[33:2]),
    .in_parent_id  (in_tdata[65:34]),
    .in_node_index (in_tdata[75:66]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_up_index  (up_index),
    .out_up_file   (up_file),
    .out_found     (out_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
  );

  // Result fields packed from the lowest bit, zero filled to whole bytes.
  assign out_tdata = {{(OUT_TDATA_W - NIDX_W - EFILE_W){1'b0}}, up_file, up_index};

endmodule

`default_nettype wire

FILE: bench/root_scoreboard_pkg.sv
// Scoreboard for the parent chain root finder: table shadow, root prediction and result checks.
`timescale 1ns / 100ps

package root_scoreboard_pkg;
  import pcrf_pkg::*;

  // One result transaction: table index and file of the root, and the found flag.
  typedef struct packed {
    logic [NIDX_W-1:0] up_index;
    logic [FILE_W-1:0] up_file;
    logic              found;
  } root_result_t;

  class root_scoreboard;
    logic [ID_W-1:0]    node_ids   [NUM_FILES*MAX_NODES];
    logic [ID_W-1:0]    parent_ids [NUM_FILES*MAX_NODES];
    int unsigned        fill_count [NUM_FILES];
    int unsigned        scan_files;
    root_result_t       pending_roots [$];
    int unsigned        mismatches;

    // State after reset: all tables empty, every file scanned.
    function void reset_state();
      foreach (fill_count[i]) fill_count[i] = 0;
      scan_files = NUM_FILES_RST;
      mismatches = 0;
      pending_roots.delete();
    endfunction

    function void set_num_files(logic [CFG_NF_W-1:0] value);
      scan_files = value;
    endfunction

    function int unsigned outstanding();
      return pending_roots.size();
    endfunction

    function void note_mismatch(string what, root_result_t want, root_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] %s: expected idx=%0d file=%0d found=%0d, got idx=%0d file=%0d found=%0d",
                 $realtime, what, want.up_index, want.up_file, want.found,
                 got.up_index, got.up_file, got.found);
      end
    endfunction

    // One linear pass over a file. The sought id moves up at every matching entry,
    // so several links can be taken in one pass.
    function bit follow_file(int unsigned f, inout logic [ID_W-1:0] sought,
                             output int unsigned pos);
      int unsigned base;
      base = f * MAX_NODES;
      pos = 0;
      for (int unsigned k = 0; k < fill_count[f]; k++) begin
        if (node_ids[base+k] == sought) begin
          if (parent_ids[base+k] == NO_PARENT) begin
            pos = k;
            return 1'b1;
          end
          sought = parent_ids[base+k];
        end
      end
      return 1'b0;
    endfunction

    // Root search: passes over the node's own file first, then over the first files.
    function root_result_t find_root(logic [FILE_W-1:0] f, logic [NIDX_W-1:0] idx);
      logic [ID_W-1:0] sought;
      int unsigned     pos;
      int unsigned     nf;
      root_result_t    res;
      res.up_index = idx;
      res.up_file  = f;
      res.found    = 1'b0;
      if (idx >= fill_count[f]) return res;
      sought = parent_ids[f*MAX_NODES+idx];
      if (sought == NO_PARENT) begin
        res.found = 1'b1;
        return res;
      end
      nf = (scan_files > NUM_FILES) ? NUM_FILES : scan_files;
      for (int lvl = 0; lvl < CHAIN_PASSES; lvl++) begin
        if (follow_file(f, sought, pos)) begin
          res.up_index = NIDX_W'(pos);
          res.found    = 1'b1;
          return res;
        end
      end
      for (int lvl = 0; lvl < CHAIN_PASSES; lvl++) begin
        for (int unsigned g = 0; g < nf; g++) begin
          if (follow_file(g, sought, pos)) begin
            res.up_index = NIDX_W'(pos);
            res.up_file  = FILE_W'(g);
            res.found    = 1'b1;
            return res;
          end
        end
      end
      return res;
    endfunction

    // Apply one accepted input transaction to the shadow tables.
    function void note_input(logic [REQ_W-1:0] req, logic [FILE_W-1:0] f,
                             logic [ID_W-1:0] id, logic [ID_W-1:0] par,
                             logic [NIDX_W-1:0] idx);
      case (req)
        REQ_CLEAR: begin
          foreach (fill_count[i]) fill_count[i] = 0;
        end
        REQ_LOAD: begin
          if (fill_count[f] < MAX_NODES) begin
            node_ids[f*MAX_NODES+fill_count[f]]   = id;
            parent_ids[f*MAX_NODES+fill_count[f]] = par;
            fill_count[f]++;
          end
        end
        REQ_QUERY: begin
          pending_roots.push_back(find_root(f, idx));
        end
        default: begin
          // Unknown requests leave the tables alone.
        end
      endcase
    endfunction

    // Compare one accepted result transaction with the oldest expected root.
    function void check_result(logic [NIDX_W-1:0] idx, logic [FILE_W-1:0] f, logic found);
      root_result_t got;
      root_result_t want;
      got.up_index = idx;
      got.up_file  = f;
      got.found    = found;
      if (pending_roots.size() == 0) begin
        want = '0;
        note_mismatch("result with nothing pending", want, got);
      end else begin
        want = pending_roots.pop_front();
        if (got !== want) note_mismatch("root mismatch", want, got);
      end
    endfunction

    // Register read-back against the shadow copy.
    function void check_num_files(logic [CFG_NF_W-1:0] value);
      if (value !== CFG_NF_W'(scan_files)) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] num_files read-back: expected %0d, got %0d",
                   $realtime, scan_files, value);
        end
      end
    endfunction
  endclass

endpackage

FILE: bench/tb_top.sv
// Testbench top for the parent chain root finder core: stimulus, handshakes and watchdog.
`timescale 1ns / 100ps

module tb_top;
  import pcrf_pkg::*;
  import root_scoreboard_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam int IDLE_PCT     = 38;
  localparam int STALL_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 16;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [REQ_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  root_scoreboard sb;
  bit             no_idle;
  int unsigned    quiet_cycles = 0;

  parent_chain_root_finder_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result monitor, receiver backpressure and the no-progress watchdog.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata[9:0], out_tdata[11:10], out_tuser);
    end
    out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Send one input transaction, with random idle cycles ahead of it.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [FILE_W-1:0] f,
                           input logic [ID_W-1:0] id, input logic [ID_W-1:0] par,
                           input logic [NIDX_W-1:0] idx);
    while (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{(IN_TDATA_W-76){1'b0}}, idx, par, id, f};
    do @(posedge clk); while (!in_tready);
    sb.note_input(req, f, id, par, idx);
  endtask

  // Stop sending and wait until every expected root has arrived, then let
  // trailing clear or load work settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One APB transaction on the num_files register; a read is checked against the shadow.
  task automatic cfg_access(input bit wr, input logic [CFG_NF_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_NUM_FILES, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) sb.set_num_files(value);
    else sb.check_num_files(prdata[CFG_NF_W-1:0]);
  endtask

  // Ids come mostly from a tiny pool so that chains form across entries and files.
  function automatic logic [ID_W-1:0] pick_id();
    return ($urandom_range(99) < 85) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
  endfunction

  // A clear, a burst of loads and a run of queries, with some noise mixed in.
  task automatic run_random_batch();
    int unsigned       n_loads;
    int unsigned       n_queries;
    int unsigned       roll;
    logic [FILE_W-1:0] f;
    logic [ID_W-1:0]   par;
    logic [NIDX_W-1:0] idx;
    send_item(REQ_CLEAR, FILE_W'($urandom), $urandom, $urandom, NIDX_W'($urandom));
    n_loads = $urandom_range(14, 1);
    for (int unsigned i = 0; i < n_loads; i++) begin
      f   = FILE_W'($urandom_range(3));
      par = ($urandom_range(99) < 25) ? NO_PARENT : pick_id();
      send_item(REQ_LOAD, f, pick_id(), par, NIDX_W'($urandom));
    end
    n_queries = $urandom_range(8, 3);
    for (int unsigned i = 0; i < n_queries; i++) begin
      roll = $urandom_range(99);
      f    = FILE_W'($urandom_range(3));
      if (roll < 8) begin
        send_item(REQ_UNKNOWN, f, $urandom, $urandom, NIDX_W'($urandom));
      end else if (roll < 11) begin
        send_item(REQ_CLEAR, f, $urandom, $urandom, NIDX_W'($urandom));
      end else if (roll < 21) begin
        par = ($urandom_range(99) < 25) ? NO_PARENT : pick_id();
        send_item(REQ_LOAD, f, pick_id(), par, NIDX_W'($urandom));
      end else begin
        if ((sb.fill_count[f] != 0) && ($urandom_range(99) < 85)) begin
          idx = NIDX_W'($urandom_range(sb.fill_count[f] - 1));
        end else begin
          idx = NIDX_W'($urandom);
        end
        send_item(REQ_QUERY, f, $urandom, $urandom, idx);
      end
    end
  endtask

  initial begin
    logic [CFG_NF_W-1:0] nf_setting;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= REQ_CLEAR;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    no_idle    = 1'b0;
    sb = new;
    sb.reset_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value of the register, then the directed cases.
    cfg_access(1'b0, '0);
    send_item(REQ_QUERY, 2'd0, 32'h0, 32'h0, 10'd0);
    send_item(REQ_UNKNOWN, 2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 10'd1023);
    send_item(REQ_LOAD, 2'd0, 32'h7FFF_FFFF, NO_PARENT, 10'd0);
    send_item(REQ_LOAD, 2'd0, 32'h0000_0000, 32'h8000_0000, 10'd0);
    send_item(REQ_LOAD, 2'd0, 32'h8000_0000, 32'h7FFF_FFFF, 10'd0);
    send_item(REQ_LOAD, 2'd1, 32'h0000_0005, 32'h0000_0000, 10'd0);
    send_item(REQ_LOAD, 2'd1, 32'h0000_0006, 32'h0000_0006, 10'd0);
    send_item(REQ_LOAD, 2'd2, 32'hFFFF_FFFF, NO_PARENT, 10'd0);
    send_item(REQ_LOAD, 2'd3, 32'h5555_5555, 32'hAAAA_AAAA, 10'd0);
    send_item(REQ_LOAD, 2'd3, 32'hAAAA_AAAA, 32'h1234_5678, 10'd0);
    // Node that is its own root, chains inside a file and across files.
    send_item(REQ_QUERY, 2'd0, 32'h0, 32'h0, 10'd0);
    send_item(REQ_QUERY, 2'd0, 32'h0, 32'h0, 10'd1);
    send_item(REQ_QUERY, 2'd0, 32'h0, 32'h0, 10'd2);
    send_item(REQ_QUERY, 2'd1, 32'h0, 32'h0, 10'd0);
    // A self loop and a dangling parent find no root; an index past the count misses.
    send_item(REQ_QUERY, 2'd1, 32'h0, 32'h0, 10'd1);
    send_item(REQ_QUERY, 2'd3, 32'h0, 32'h0, 10'd0);
    send_item(REQ_QUERY, 2'd3, 32'h0, 32'h0, 10'd1023);
    send_item(REQ_QUERY, 2'd2, 32'h0, 32'h0, 10'd0);
    send_item(REQ_CLEAR, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023);
    send_item(REQ_QUERY, 2'd0, 32'h0, 32'h0, 10'd0);
    wait_drained();

    // Register settings from the extremes, with random traffic under each.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: nf_setting = 3'd0;
        1: nf_setting = 3'd1;
        2: nf_setting = 3'd7;
        3: nf_setting = CFG_NF_W'($urandom_range(7));
        default: nf_setting = 3'd4;
      endcase
      cfg_access(1'b1, nf_setting);
      cfg_access(1'b0, '0);
      no_idle = (p == 2);
      run_random_batch();
      // Hold the sender back once until every pending root is out.
      if (p == 1) begin
        wait_drained();
        run_random_batch();
      end
      wait_drained();
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: parent_chain_root_finder_core.f
rtl/core/pcrf_pkg.sv
rtl/core/pcrf_ram.sv
rtl/core/pcrf_dp.sv
rtl/core/pcrf_ctrl.sv
rtl/core/parent_chain_root_finder_core.sv
bench/root_scoreboard_pkg.sv
bench/tb_top.sv
